>>> design/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants for the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam int MaxPoints = 16;
    localparam int IdxW      = $clog2(MaxPoints);
    localparam int CntW      = $clog2(MaxPoints + 1);

    typedef logic [1:0] status_t;
    localparam status_t StOk    = 2'd0;
    localparam status_t StEmpty = 2'd1;
    localparam status_t StOrder = 2'd2;
    localparam status_t StRange = 2'd3;

    localparam logic OpLoad  = 1'b0;
    localparam logic OpQuery = 1'b1;

endpackage

>>> design/piecewise_linear_interpolator_unit.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_unit
// Breakpoint table lookup with linear interpolation between neighbors.
// ----------------------------------------------------------------------------
// A load item is written into both tables when it is accepted. A query keeps
// the block busy while it steps through its states: it reads the x memory once
// per entry to check the order, checks the range, walks the x memory again to
// find the segment, reads the two neighbors and forms the two weighted products
// and their sum, runs a one-bit-per-cycle restoring divider and moves the result
// into the output register once that register is free. An empty table, a failed
// check or an exact hit on the first x ends the query early. The result sits
// in an output register, so the next item is accepted while it waits. Both
// tables are single-port synchronous RAMs with a registered read.
module piecewise_linear_interpolator_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: entry_index[3:0], breakpoint_x[35:4], breakpoint_y[67:36],
    // query_x[99:68], zeros[103:100]
    input  logic [103:0] s_tdata,
    // tuser: opcode
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: status[1:0], interp_value[33:2], zeros[39:34]
    output logic [39:0] m_tdata
);
    import pli_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK_RD, S_CHK, S_RNG, S_SRCH, S_NB_RD, S_NB_A, S_NB_B,
        S_MUL, S_SUM, S_DIV, S_DONE
    } state_t;

    logic [31:0] x_mem [MaxPoints];
    logic [31:0] y_mem [MaxPoints];
    logic [31:0] x_rd, y_rd;
    logic [IdxW-1:0] addr;
    logic        we;

    state_t      state_reg;
    logic [4:0]  cnt_reg;
    logic [CntW-1:0] n;
    logic [CntW-1:0] k_reg;
    logic signed [31:0] q_reg, prev_reg, first_reg;
    logic signed [31:0] xa_reg, xb_reg, ya_reg, yb_reg;
    logic [63:0] pa_reg, pb_reg, m_reg, rem_reg, d_reg;
    logic        neg_reg;
    logic [6:0]  dcnt_reg;
    status_t     res_st_reg;
    logic [31:0] res_val_reg;
    logic        ovalid_reg;
    logic [1:0]  ost_reg;
    logic [31:0] oval_reg;
    logic        busy;

    assign n = (cnt_reg > 5'(MaxPoints)) ? CntW'(MaxPoints) : CntW'(cnt_reg);
    assign busy = (state_reg != S_IDLE);
    assign s_tready = !busy;
    assign we = s_tvalid && s_tready && (s_tuser == OpLoad);
    assign m_tvalid = ovalid_reg;
    assign m_tdata = {6'd0, oval_reg, ost_reg};

    always_comb
    begin
        if (we)
            addr = s_tdata[IdxW-1:0];
        else
            addr = k_reg[IdxW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            x_mem[addr] <= s_tdata[35:4];
            y_mem[addr] <= s_tdata[67:36];
        end
        x_rd <= x_mem[addr];
        y_rd <= y_mem[addr];
    end

    logic [32:0] dxb, dxa, dd;
    logic [31:0] mya, myb;
    logic [64:0] trial;
    assign dxb = 33'($signed(q_reg) - $signed({xa_reg[31], xa_reg}));
    assign dxa = 33'($signed({xb_reg[31], xb_reg}) - $signed(q_reg));
    assign dd  = 33'($signed({xb_reg[31], xb_reg}) - $signed({xa_reg[31], xa_reg}));
    assign mya = ya_reg[31] ? 32'(-ya_reg) : ya_reg;
    assign myb = yb_reg[31] ? 32'(-yb_reg) : yb_reg;
    assign trial = {rem_reg, m_reg[63]} - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
            k_reg      <= '0;
            dcnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                cnt_reg <= cfg_wdata;
            if (state_reg == S_DONE && (!ovalid_reg || m_tready))
                ovalid_reg <= 1'b1;
            else if (ovalid_reg && m_tready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && s_tready && s_tuser == OpQuery)
                    begin
                        q_reg <= s_tdata[99:68];
                        k_reg <= '0;
                        if (n == '0)
                        begin
                            res_st_reg  <= StEmpty;
                            res_val_reg <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                            state_reg <= S_CHK_RD;
                    end
                end
                S_CHK_RD:
                begin
                    k_reg <= k_reg + 1'b1;
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    // x_rd holds entry k_reg-1.
                    if (k_reg == CntW'(1))
                        first_reg <= x_rd;
                    if (k_reg != CntW'(1) && $signed(prev_reg) > $signed(x_rd))
                    begin
                        res_st_reg  <= StOrder;
                        res_val_reg <= '0;
                        state_reg <= S_DONE;
                    end
                    else if (k_reg == n)
                    begin
                        prev_reg <= x_rd;
                        state_reg <= S_RNG;
                    end
                    else
                    begin
                        prev_reg <= x_rd;
                        state_reg <= S_CHK_RD;
                    end
                end
                S_RNG:
                begin
                    if ($signed(q_reg) < $signed(first_reg) || $signed(q_reg) > $signed(prev_reg))
                    begin
                        res_st_reg  <= StRange;
                        res_val_reg <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_NB_RD;
                        if (q_reg == first_reg)
                        begin
                            k_reg    <= '0;
                            dcnt_reg <= 7'd1;
                        end
                        else
                        begin
                            k_reg    <= CntW'(1);
                            dcnt_reg <= 7'd0;
                        end
                    end
                end
                S_NB_RD:
                    state_reg <= S_SRCH;
                S_SRCH:
                begin
                    if (dcnt_reg == 7'd1)
                    begin
                        res_st_reg  <= StOk;
                        res_val_reg <= y_rd;
                        state_reg <= S_DONE;
                    end
                    else if (k_reg < n - 1'b1 && $signed(x_rd) < $signed(q_reg))
                    begin
                        k_reg <= k_reg + 1'b1;
                        state_reg <= S_NB_RD;
                        dcnt_reg <= 7'd2;
                    end
                    else
                    begin
                        xb_reg <= x_rd;
                        yb_reg <= y_rd;
                        k_reg <= k_reg - 1'b1;
                        state_reg <= S_NB_A;
                    end
                end
                S_NB_A:
                    state_reg <= S_NB_B;
                S_NB_B:
                begin
                    xa_reg <= x_rd;
                    ya_reg <= y_rd;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    pb_reg <= 64'(dxb * myb);
                    pa_reg <= 64'(dxa * mya);
                    d_reg  <= 64'(dd);
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    if (yb_reg[31] == ya_reg[31])
                    begin
                        m_reg <= pb_reg + pa_reg;
                        neg_reg <= yb_reg[31];
                    end
                    else if (pb_reg >= pa_reg)
                    begin
                        m_reg <= pb_reg - pa_reg;
                        neg_reg <= yb_reg[31];
                    end
                    else
                    begin
                        m_reg <= pa_reg - pb_reg;
                        neg_reg <= ya_reg[31];
                    end
                    rem_reg  <= '0;
                    dcnt_reg <= 7'd64;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (!trial[64])
                    begin
                        rem_reg <= trial[63:0];
                        m_reg   <= {m_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[62:0], m_reg[63]};
                        m_reg   <= {m_reg[62:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dcnt_reg == 7'd1)
                    begin
                        res_st_reg  <= StOk;
                        res_val_reg <= neg_reg ? 32'(-{m_reg[30:0], !trial[64]})
                                               : {m_reg[30:0], !trial[64]};
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!ovalid_reg || m_tready)
                    begin
                        ost_reg  <= res_st_reg;
                        oval_reg <= res_val_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_tready)
        else $error("item accepted while a query is in progress");
    a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (dcnt_reg != 7'd0))
        else $error("divider ran past its last step");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] != StOk) |-> (m_tdata[33:2] == 32'd0))
        else $error("nonzero value with error status");

endmodule
